>>> sv/bfh_pkg.sv
package bfh_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int ALPHABET_SIZE = 256;

    localparam int ADDR_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int PTR_W   = ADDR_W + 1;
    localparam int OCC_MAX = 65535;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
    } bfh_cmd_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] occurrences;
        logic        found;
    } bfh_res_t;

    localparam logic MODE_COUNT = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // wide counters report at most 16 bits
    function automatic logic [15:0] sat_occ(input logic [COUNT_WIDTH-1:0] c);
        if (32'(c) > 32'(OCC_MAX))
        begin
            return 16'hFFFF;
        end
        else
        begin
            return 16'(c);
        end
    endfunction

endpackage

>>> sv/byte_frequency_histogram.sv
// Channel  Dir  Handshake               Payload
// cmd      in   cmd_valid / cmd_stall   bfh_cmd_t (mode, in_byte)
// res      out  res_valid / res_stall   bfh_res_t (out_byte, occurrences, found)
//
// One request at a time; cmd_stall is high while a request is at work.
// Count: bin read, then increment and write back; no result.
// Fetch: accept, then a read step and a check step per bin examined, then load
// the result; when the scan runs off the end, one more read step comes first.
// The bin memory has one read and one write port; the read is registered,
// which splits each bin into a read step and a check step. Per-bin valid flops
// clear at reset and at the end of a pass, so no clearing sweep is needed.
// A waiting result does not block counts; a fetch holds in its last cycle
// until the output register is free.
module byte_frequency_histogram
    import bfh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  bfh_cmd_t cmd,
    output logic     res_valid,
    input  logic     res_stall,
    output bfh_res_t res
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CNT_UPD  = 3'd1;
    localparam logic [2:0] ST_SCAN_RD  = 3'd2;
    localparam logic [2:0] ST_SCAN_CHK = 3'd3;
    localparam logic [2:0] ST_FINISH   = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] BIN_MAX = {COUNT_WIDTH{1'b1}};

    logic [2:0]             state_reg, state_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [ALPHABET_SIZE-1:0] vbit_reg, vbit_next;
    logic                   found_reg, found_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   res_valid_reg, res_valid_next;
    bfh_res_t               res_reg, res_next;

    logic [COUNT_WIDTH-1:0] mem [ALPHABET_SIZE];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vbit_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic                   accept;
    logic                   out_free;
    logic                   finish_load;

    assign accept   = cmd_valid && !cmd_stall;
    assign out_free = !res_valid_reg || !res_stall;
    assign cur_cnt  = rd_vbit_reg ? rd_data_reg : '0;
    assign finish_load = (state_reg == ST_FINISH) && out_free;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vbit_reg <= vbit_reg[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        addr_next      = addr_reg;
        vbit_next      = vbit_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_data        = cur_cnt + 1'b1;
        rd_addr        = ptr_reg[ADDR_W-1:0];
        cmd_stall      = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = cmd.in_byte[ADDR_W-1:0];
                if (accept)
                begin
                    if (cmd.mode == MODE_FETCH)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else if (9'(cmd.in_byte) < 9'(ALPHABET_SIZE))
                    begin
                        addr_next  = cmd.in_byte[ADDR_W-1:0];
                        state_next = ST_CNT_UPD;
                    end
                end
            end
            ST_CNT_UPD:
            begin
                // saturating increment, bin read last cycle
                if (cur_cnt != BIN_MAX)
                begin
                    wr_en = 1'b1;
                    vbit_next[addr_reg] = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                if (ptr_reg == PTR_W'(ALPHABET_SIZE))
                begin
                    found_next = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (cur_cnt != '0)
                begin
                    found_next = 1'b1;
                    cnt_next   = cur_cnt;
                    state_next = ST_FINISH;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.found       = found_reg;
                    res_next.occurrences = sat_occ(cnt_reg);
                    res_next.out_byte    = found_reg ? 8'(ptr_reg[ADDR_W-1:0]) : 8'd0;
                    if (found_reg)
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                    else
                    begin
                        // pass over: drop every bin
                        ptr_next  = '0;
                        vbit_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            vbit_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            vbit_reg      <= vbit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        found_reg <= found_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside the finish step");

    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_load && !found_reg) |=> (vbit_reg == '0 && ptr_reg == '0))
        else $error("end of pass did not clear bins and scan pointer");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.found) |-> (res.occurrences != 16'd0))
        else $error("found result with zero count");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CHK) |-> (ptr_reg < PTR_W'(ALPHABET_SIZE)))
        else $error("scan pointer past alphabet while checking a bin");

endmodule

>>> tb/tb_byte_frequency_histogram.sv
module tb_byte_frequency_histogram;
    import bfh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned  CYCLE_LIMIT = 4_000_000;
    localparam int unsigned  TAIL_CYCLES = 2 * ALPHABET_SIZE + 10;
    localparam int unsigned  HEAVY_COUNTS = 200;
    localparam int           RANDOM_ITEMS = 1600;
    localparam longint unsigned BIN_TOP  = (64'd1 << COUNT_WIDTH) - 1;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    bfh_cmd_t cmd       = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    bfh_res_t res;

    byte_frequency_histogram dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // expected histogram state
    longint unsigned tally [ALPHABET_SIZE];
    int unsigned     scan_ptr;

    bfh_cmd_t cmd_backlog [$];
    bfh_res_t expected_bins [$];

    int errors;
    int unsigned results_checked;
    int unsigned counts_sent;
    int unsigned fetches_sent;
    int unsigned bins_returned;
    int unsigned passes_ended;
    int unsigned peak_occurrences;
    int unsigned cycle_count;

    // sender burst state
    int unsigned burst_left;
    int unsigned gap_left;

    // receiver stall state
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned stall_style;
    logic        long_hold_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycle_count, expected_bins.size());
            $display("tb_byte_frequency_histogram failed");
            $finish;
        end
    end

    function automatic void predict_request(input bfh_cmd_t c);
        int unsigned p;
        bfh_res_t    r;
        if (c.mode == MODE_COUNT)
        begin
            counts_sent++;
            if (int'(c.in_byte) < ALPHABET_SIZE && tally[c.in_byte] < BIN_TOP)
            begin
                tally[c.in_byte]++;
            end
        end
        else
        begin
            fetches_sent++;
            r = '0;
            for (p = scan_ptr; p < ALPHABET_SIZE; p++)
            begin
                if (tally[p] != 0)
                begin
                    break;
                end
            end
            if (p < ALPHABET_SIZE)
            begin
                r.out_byte    = 8'(p);
                r.occurrences = (tally[p] > OCC_MAX) ? 16'hFFFF : 16'(tally[p]);
                r.found       = 1'b1;
                scan_ptr      = (p + 1) & 9'h1FF;
            end
            else
            begin
                foreach (tally[i])
                begin
                    tally[i] = 0;
                end
                scan_ptr = 0;
            end
            expected_bins.push_back(r);
        end
    endfunction

    task automatic report_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    task automatic push_request(input logic m, input logic [7:0] b);
        bfh_cmd_t c;
        c.mode    = m;
        c.in_byte = b;
        cmd_backlog.push_back(c);
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || cmd_valid || expected_bins.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // driver: bursts of requests separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic     next_valid;
        bfh_cmd_t next_cmd;
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            cmd        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            next_valid = cmd_valid;
            next_cmd   = cmd;
            if (!cmd_valid || !cmd_stall)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    next_cmd   = cmd_backlog.pop_front();
                    next_valid = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 32);
                        gap_left   <= ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : 0;
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            cmd_valid <= next_valid;
            cmd       <= next_cmd;
        end
    end

    // receiver: stall style changes every so often, plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin : drive_stall
        if (!rst_n)
        begin
            res_stall      <= 1'b0;
            hold_left      <= 0;
            phase_left     <= 0;
            stall_style    <= 0;
            long_hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else if (!long_hold_done && results_checked >= 40)
        begin
            // long enough for a fetch to back up into cmd_stall
            hold_left      <= 1500;
            long_hold_done <= 1'b1;
            res_stall      <= 1'b1;
        end
        else if ($urandom_range(0, 4999) == 0)
        begin
            hold_left <= $urandom_range(100, 600);
            res_stall <= 1'b1;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_style <= $urandom_range(0, 2);
                phase_left  <= $urandom_range(20, 200);
            end
            else
            begin
                phase_left <= phase_left - 1;
            end
            case (stall_style)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                default: res_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : watch_ports
        bfh_res_t want;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                predict_request(cmd);
            end
            if (res_valid && !res_stall)
            begin
                results_checked <= results_checked + 1;
                if (res.found)
                begin
                    bins_returned++;
                    if (res.occurrences > peak_occurrences)
                    begin
                        peak_occurrences = res.occurrences;
                    end
                end
                else
                begin
                    passes_ended++;
                end
                if (expected_bins.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, %s %0d count %0d found %0b",
                             $time, "actual byte", res.out_byte, res.occurrences, res.found);
                end
                else
                begin
                    want = expected_bins.pop_front();
                    report_field("out_byte", want.out_byte, res.out_byte);
                    report_field("occurrences", want.occurrences, res.occurrences);
                    report_field("found", want.found, res.found);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] pool [16];
        logic       seen [256];
        int         generated;
        int         pool_size;
        int         n_counts;
        int         distinct;
        int         n_fetch;
        int         mid_count_at;
        int         k;
        logic [7:0] b;

        errors           = 0;
        results_checked  = 0;
        counts_sent      = 0;
        fetches_sent     = 0;
        bins_returned    = 0;
        passes_ended     = 0;
        peak_occurrences = 0;
        cycle_count      = 0;
        scan_ptr         = 0;
        foreach (tally[i])
        begin
            tally[i] = 0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: byte extremes, full pass, empty fetch, counts during a scan
        push_request(MODE_COUNT, 8'h00);
        push_request(MODE_COUNT, 8'hFF);
        push_request(MODE_COUNT, 8'h80);
        push_request(MODE_COUNT, 8'h01);
        push_request(MODE_COUNT, 8'h01);
        push_request(MODE_FETCH, 8'hFF);
        push_request(MODE_FETCH, 8'h00);
        push_request(MODE_FETCH, 8'h55);
        push_request(MODE_FETCH, 8'hAA);
        push_request(MODE_FETCH, 8'h00);
        push_request(MODE_FETCH, 8'hFF);
        push_request(MODE_COUNT, 8'h10);
        push_request(MODE_COUNT, 8'h20);
        push_request(MODE_FETCH, 8'h00);
        push_request(MODE_COUNT, 8'h05);  // below scan point: dropped at end of pass
        push_request(MODE_COUNT, 8'h20);  // above scan point: returned with new count
        push_request(MODE_COUNT, 8'h30);
        push_request(MODE_FETCH, 8'h00);
        push_request(MODE_FETCH, 8'h00);
        push_request(MODE_FETCH, 8'h00);
        push_request(MODE_FETCH, 8'h00);
        wait_drained();

        // pile up one bin, then read it out
        for (int i = 0; i < HEAVY_COUNTS; i++)
        begin
            push_request(MODE_COUNT, 8'h7F);
        end
        push_request(MODE_COUNT, 8'h00);
        push_request(MODE_FETCH, 8'h12);
        push_request(MODE_FETCH, 8'hED);
        push_request(MODE_FETCH, 8'h00);
        wait_drained();

        // random: mostly count-then-drain passes, some noise
        generated = 0;
        while (generated < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                for (int i = 0; i < 256; i++)
                begin
                    seen[i] = 1'b0;
                end
                pool_size = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 6);
                for (int i = 0; i < pool_size; i++)
                begin
                    case ($urandom_range(0, 7))
                        0:       pool[i] = 8'h00;
                        1:       pool[i] = 8'hFF;
                        default: pool[i] = 8'($urandom_range(0, 255));
                    endcase
                end
                n_counts = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                       : $urandom_range(1, 20);
                distinct = 0;
                for (int i = 0; i < n_counts; i++)
                begin
                    b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                    : pool[$urandom_range(0, pool_size - 1)];
                    if (!seen[b])
                    begin
                        seen[b] = 1'b1;
                        distinct++;
                    end
                    push_request(MODE_COUNT, b);
                end
                n_fetch      = distinct + 1;
                mid_count_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_fetch - 1) : -1;
                for (int i = 0; i < n_fetch; i++)
                begin
                    if (i == mid_count_at)
                    begin
                        push_request(MODE_COUNT, 8'($urandom_range(0, 255)));
                        n_fetch++;
                        generated++;
                    end
                    push_request(MODE_FETCH, 8'($urandom_range(0, 255)));
                end
                // occasionally one extra fetch past the drain
                if ($urandom_range(0, 7) == 0)
                begin
                    push_request(MODE_FETCH, 8'($urandom_range(0, 255)));
                    n_fetch++;
                end
                generated += n_counts + n_fetch;
            end
            else
            begin
                k = $urandom_range(1, 20);
                for (int i = 0; i < k; i++)
                begin
                    push_request(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
                generated += k;
            end
        end
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_bins.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived, expected byte %0d count %0d found %0b",
                     $time, expected_bins.size(), expected_bins[0].out_byte,
                     expected_bins[0].occurrences, expected_bins[0].found);
        end

        $display("run covered %0d count and %0d fetch requests, %0d bins returned",
                 counts_sent, fetches_sent, bins_returned);
        $display("%0d passes ended with a clear, peak count seen %0d, %0d errors",
                 passes_ended, peak_occurrences, errors);
        if (errors == 0)
        begin
            $display("tb_byte_frequency_histogram passed");
        end
        else
        begin
            $display("tb_byte_frequency_histogram failed");
        end
        $finish;
    end

endmodule

>>> byte_frequency_histogram.f
sv/bfh_pkg.sv
sv/byte_frequency_histogram.sv
tb/tb_byte_frequency_histogram.sv
